@@ rtl/core/rau_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Opcodes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rau_pkg;
	localparam int W = 32;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_INV = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		DC_NONE,
		DC_LOAD,    // latch operands
		DC_MUL,     // cross products into n/d
		DC_NORM,    // start normalize: magnitudes, sign
		DC_GCD,     // one gcd step
		DC_DSTART,  // start the two divisions
		DC_DSTEP,   // one division bit
		DC_FIN      // apply sign, quotients into n/d
	} dcmd_kind_t;

	typedef struct packed {
		dcmd_kind_t kind;
		logic       sel;  // DC_MUL: 0 first product set, 1 divide second pass
	} dcmd_t;

	typedef struct packed {
		logic nzero;     // numerator zero
		logic gcd_done;
		logic div_done;
	} dstat_t;
endpackage
`default_nettype wire

@@ rtl/core/rau_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rau_datapath: operand registers, multiplier, binary gcd and serial divider
// Cross products, reduction by gcd and sign handling under controller command.
// ----------------------------------------------------------------------------
module rau_datapath (
	input  wire logic                clk,
	input  wire rau_pkg::dcmd_t      cmd,
	input  wire logic [2:0]          opcode,
	input  wire logic [rau_pkg::W-1:0] a_num,
	input  wire logic [rau_pkg::W-1:0] a_den,
	input  wire logic [rau_pkg::W-1:0] b_num,
	input  wire logic [rau_pkg::W-1:0] b_den,
	output rau_pkg::dstat_t          stat,
	output logic [rau_pkg::W-1:0]    n_q,
	output logic [rau_pkg::W-1:0]    d_q
);
	import rau_pkg::*;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0] an_q, ad_q, bn_q, bd_q;
	logic [2:0]   op_q;
	logic [W-1:0] mn_q, md_q, x_q, y_q, g_q;
	logic [CW-1:0] k_q, cnt_q;
	logic         neg_q, kdone_q;
	logic [W-1:0] qn_q, qd_q, rn_q, rd_q;
	logic [W-1:0] p0, p1, p2, p3;
	logic [W-1:0] mag_n, mag_d, nrn, nrd;

	// cross products, each a 32x32 multiply keeping the low half
	always_comb begin
		p0 = an_q * bd_q;
		p1 = bn_q * ad_q;
		p2 = an_q * bn_q;
		p3 = ad_q * bd_q;
		mag_n = n_q[W-1] ? (W'(0) - n_q) : n_q;
		mag_d = d_q[W-1] ? (W'(0) - d_q) : d_q;
		nrn = {rn_q[W-2:0], qn_q[W-1]};
		nrd = {rd_q[W-2:0], qd_q[W-1]};
	end

	assign stat.nzero    = (n_q == '0);
	assign stat.gcd_done = kdone_q && (x_q == y_q);
	assign stat.div_done = (cnt_q == '0);

	always_ff @(posedge clk) begin
		unique case (cmd.kind)
			DC_NONE: ;
			DC_LOAD: begin
				an_q <= a_num; ad_q <= a_den; bn_q <= b_num; bd_q <= b_den;
				op_q <= opcode;
				if (opcode == OP_INV) begin
					n_q <= a_den; d_q <= a_num;
				end else if (opcode == OP_DIV) begin
					n_q <= b_den; d_q <= b_num;
				end else if (opcode > OP_INV) begin
					n_q <= '0; d_q <= W'(1);
				end
			end
			DC_MUL: begin
				if (cmd.sel) begin
					bn_q <= n_q; bd_q <= d_q;
					n_q <= an_q * n_q; d_q <= ad_q * d_q;
				end else if (op_q == OP_ADD) begin
					n_q <= p0 + p1; d_q <= p3;
				end else if (op_q == OP_SUB) begin
					n_q <= p0 - p1; d_q <= p3;
				end else begin
					n_q <= p2; d_q <= p3;
				end
			end
			DC_NORM: begin
				neg_q <= n_q[W-1] ^ d_q[W-1];
				mn_q <= mag_n;
				md_q <= (mag_d == '0) ? W'(1) : mag_d;
				x_q <= mag_n;
				y_q <= (mag_d == '0) ? W'(1) : mag_d;
				k_q <= '0;
				kdone_q <= 1'b0;
			end
			DC_GCD: begin
				if (!kdone_q) begin
					if (((x_q | y_q) & W'(1)) == '0) begin
						x_q <= x_q >> 1; y_q <= y_q >> 1; k_q <= k_q + 1'b1;
					end else kdone_q <= 1'b1;
				end else if (!x_q[0]) x_q <= x_q >> 1;
				else if (!y_q[0]) y_q <= y_q >> 1;
				else if (x_q > y_q) x_q <= (x_q - y_q) >> 1;
				else y_q <= (y_q - x_q) >> 1;
			end
			DC_DSTART: begin
				g_q <= x_q << k_q;
				qn_q <= mn_q; qd_q <= md_q;
				rn_q <= '0; rd_q <= '0;
				cnt_q <= CW'(W);
			end
			DC_DSTEP: begin
				cnt_q <= cnt_q - 1'b1;
				if (nrn >= g_q) begin
					rn_q <= nrn - g_q; qn_q <= {qn_q[W-2:0], 1'b1};
				end else begin
					rn_q <= nrn; qn_q <= {qn_q[W-2:0], 1'b0};
				end
				if (nrd >= g_q) begin
					rd_q <= nrd - g_q; qd_q <= {qd_q[W-2:0], 1'b1};
				end else begin
					rd_q <= nrd; qd_q <= {qd_q[W-2:0], 1'b0};
				end
			end
			DC_FIN: begin
				n_q <= neg_q ? (W'(0) - qn_q) : qn_q;
				d_q <= qd_q;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/core/rau_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rau_ctrl: sequencer of the rational arithmetic unit
// Handshakes, opcode flow, gcd and division loop control.
// ----------------------------------------------------------------------------
module rau_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [2:0]      opcode,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	input  wire rau_pkg::dstat_t stat,
	output rau_pkg::dcmd_t       cmd
);
	import rau_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_NORM, S_GCD, S_DSTART, S_DIV, S_FIN, S_OUT
	} state_t;

	state_t state_q;
	logic   second_q, div_q, busy_out;

	assign busy_out = m_tvalid && !m_tready;
	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd.sel = second_q;
		unique case (state_q)
			S_IDLE:   cmd.kind = (s_tvalid && s_tready) ? DC_LOAD : DC_NONE;
			S_MUL:    cmd.kind = DC_MUL;
			S_NORM:   cmd.kind = stat.nzero ? DC_NONE : DC_NORM;
			S_GCD:    cmd.kind = stat.gcd_done ? DC_DSTART : DC_GCD;
			S_DSTART: cmd.kind = DC_NONE;
			S_DIV:    cmd.kind = stat.div_done ? DC_FIN : DC_DSTEP;
			default:  cmd.kind = DC_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; m_tvalid <= 1'b0; second_q <= 1'b0; div_q <= 1'b0;
		end else begin
			priority if (state_q == S_OUT && !busy_out) m_tvalid <= 1'b1;
			else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (s_tvalid && s_tready) begin
					second_q <= 1'b0;
					div_q <= (opcode == OP_DIV);
					if (opcode == OP_DIV || opcode == OP_INV) state_q <= S_NORM;
					else if (opcode > OP_INV) state_q <= S_OUT;
					else state_q <= S_MUL;
				end
				S_MUL:  state_q <= S_NORM;
				S_NORM: state_q <= stat.nzero ? S_FIN : S_GCD;
				S_GCD:  if (stat.gcd_done) state_q <= S_DIV;
				S_DIV:  if (stat.div_done) state_q <= S_FIN;
				S_FIN:  begin
					if (div_q && !second_q) begin
						second_q <= 1'b1; state_q <= S_MUL;
					end else state_q <= S_OUT;
				end
				S_OUT: if (!busy_out) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_one_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !busy_out) |=> m_tvalid) else $error("result lost");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready) else $error("accept while busy");
	a_second_div: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> div_q) else $error("second pass without divide");
endmodule
`default_nettype wire

@@ rtl/core/rational_arith_unit_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arith_unit_core: signed fraction add/sub/mul/div/invert, reduced
// Results reduced by binary gcd and two bit-serial divisions.
//
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | opcode[2:0], a_num, a_den, b_num, b_den (136 bits)
// m_axis  | out | res_num, res_den (64 bits)
//
// One transaction at a time, a gcd loop plus W division steps, twice
// for divide. Zero numerator skips gcd; unused opcodes go straight to
// the output.
// Reset clears control only. Output register holds while m_tready is low;
// the next transaction is accepted and processed meanwhile.
// ----------------------------------------------------------------------------
module rational_arith_unit_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [135:0] s_tdata,  // opcode, a_num, a_den, b_num, b_den, pad
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [63:0]       m_tdata   // res_num, res_den
);
	import rau_pkg::*;

	dcmd_t  cmd;
	dstat_t stat;
	logic [W-1:0] n, d;
	logic [W-1:0] rn_q, rd_q;
	logic         ld;

	rau_ctrl u_ctrl (
		.clk, .arst_n, .s_tvalid, .s_tready, .opcode(s_tdata[2:0]),
		.m_tvalid, .m_tready, .stat, .cmd
	);

	rau_datapath u_dp (
		.clk, .cmd, .opcode(s_tdata[2:0]),
		.a_num(s_tdata[34:3]), .a_den(s_tdata[66:35]),
		.b_num(s_tdata[98:67]), .b_den(s_tdata[130:99]),
		.stat, .n_q(n), .d_q(d)
	);

	// result register loads while m_tvalid is low or m_tready is high
	assign ld = !m_tvalid || m_tready;
	always_ff @(posedge clk) begin
		if (ld) begin
			rn_q <= n; rd_q <= d;
		end
	end
	assign m_tdata = {rd_q, rn_q};
endmodule
`default_nettype wire

@@ tb/rational_arith_unit_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arith_unit_core_test: self-checking bench for the fraction unit
// Drives opcode/operand transactions, predicts the reduced fraction for each
// one and compares it with the output stream under varying backpressure.
// ----------------------------------------------------------------------------
module rational_arith_unit_core_test;
	import rau_pkg::*;

	typedef struct packed {
		logic [31:0] b_den;
		logic [31:0] b_num;
		logic [31:0] a_den;
		logic [31:0] a_num;
		logic [2:0]  opcode;
	} frac_op_t;

	typedef struct packed {
		logic [31:0] den;
		logic [31:0] num;
	} frac_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [135:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;

	frac_op_t pending_ops[$];
	frac_t    expected_fracs[$];
	int       send_idle_pct;
	int       recv_stall_pct;
	bit       hold_send;
	int       fail_count;
	int       sent_count;
	int       checked_count;

	rational_arith_unit_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [31:0] mag(logic [31:0] v);
		return v[31] ? -v : v;
	endfunction

	function automatic logic [31:0] bin_gcd(logic [31:0] x, logic [31:0] y);
		int k;
		k = 0;
		while (((x | y) & 1) == 0) begin
			x = x >> 1;
			y = y >> 1;
			k++;
		end
		while (x != y) begin
			if (!x[0])
				x = x >> 1;
			else if (!y[0])
				y = y >> 1;
			else if (x > y)
				x = (x - y) >> 1;
			else
				y = (y - x) >> 1;
		end
		return x << k;
	endfunction

	function automatic frac_t reduce(logic [31:0] n, logic [31:0] d);
		frac_t r;
		logic [31:0] mn, md, g;
		logic neg;
		r.num = n;
		r.den = d;
		if (n == 0)
			return r;
		neg = n[31] ^ d[31];
		mn = mag(n);
		md = mag(d);
		if (md == 0)
			md = 1;
		g = bin_gcd(mn, md);
		mn = mn / g;
		md = md / g;
		r.num = neg ? -mn : mn;
		r.den = md;
		return r;
	endfunction

	function automatic frac_t fraction_result(frac_op_t t);
		frac_t r, inv;
		case (t.opcode)
		OP_ADD: r = reduce(t.a_num * t.b_den + t.b_num * t.a_den, t.a_den * t.b_den);
		OP_SUB: r = reduce(t.a_num * t.b_den - t.b_num * t.a_den, t.a_den * t.b_den);
		OP_MUL: r = reduce(t.a_num * t.b_num, t.a_den * t.b_den);
		OP_DIV: begin
			inv = reduce(t.b_den, t.b_num);
			r = reduce(t.a_num * inv.num, t.a_den * inv.den);
		end
		OP_INV: r = reduce(t.a_den, t.a_num);
		default: begin
			r.num = 0;
			r.den = 1;
		end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_fracs.push_back(fraction_result(frac_op_t'(s_tdata[130:0])));
				sent_count++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_ops.size() > 0 && !hold_send
						&& $urandom_range(99, 0) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= 136'(pending_ops.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		frac_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_fracs.size() == 0) begin
					$error("unexpected result transaction num=%h den=%h", got.num, got.den);
					fail_count++;
				end else begin
					want = expected_fracs.pop_front();
					checked_count++;
					if (got.num !== want.num) begin
						$error("res_num expected %h actual %h", want.num, got.num);
						fail_count++;
					end
					if (got.den !== want.den) begin
						$error("res_den expected %h actual %h", want.den, got.den);
						fail_count++;
					end
				end
			end
			m_tready <= $urandom_range(99, 0) >= recv_stall_pct;
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(7, 0))
		0: return $urandom_range(15, 0);
		1: return -$urandom_range(15, 1);
		2: return 32'h8000_0000;
		3: return 32'h7fff_ffff;
		4: return $urandom_range(1000, 0) << $urandom_range(20, 0);
		5: return -($urandom_range(1000, 1) << $urandom_range(20, 0));
		default: return $urandom;
		endcase
	endfunction

	task automatic add_op(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd);
		frac_op_t t;
		t.opcode = op;
		t.a_num = an;
		t.a_den = ad;
		t.b_num = bn;
		t.b_den = bd;
		pending_ops.push_back(t);
	endtask

	task automatic drain();
		while (pending_ops.size() > 0 || s_tvalid || expected_fracs.size() > 0)
			@(posedge clk);
	endtask

	task automatic run_phase(int n, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (n)
			add_op($urandom_range(9, 0) == 0 ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4, 0)),
				rand_word(), rand_word(), rand_word(), rand_word());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		hold_send = 1'b0;
		fail_count = 0;
		sent_count = 0;
		checked_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		add_op(OP_ADD, 1, 2, 1, 3);
		add_op(OP_SUB, 1, 2, 1, 2);
		add_op(OP_SUB, 1, 3, 1, 2);
		add_op(OP_MUL, -6, 4, 2, -3);
		add_op(OP_DIV, 3, 4, -9, 8);
		add_op(OP_DIV, 3, 4, 0, 8);
		add_op(OP_INV, -4, 6, 0, 0);
		add_op(OP_INV, 0, 5, 0, 0);
		add_op(OP_ADD, 0, 0, 0, 0);
		add_op(OP_MUL, 5, 0, 7, 3);
		add_op(OP_MUL, 32'h8000_0000, 1, 1, 1);
		add_op(OP_INV, 1, 32'h8000_0000, 0, 0);
		add_op(OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		add_op(OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		add_op(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_op(3'd5, 1, 1, 1, 1);
		add_op(3'd6, 2, 3, 4, 5);
		add_op(3'd7, -1, -1, -1, -1);
		drain();

		// hold the sender while the output side drains and a queued op waits
		hold_send = 1'b1;
		run_phase(0, 0, 0);
		add_op(OP_MUL, 12, 18, -5, 10);
		repeat (20) @(posedge clk);
		hold_send = 1'b0;
		drain();

		run_phase(175, 0, 0);
		run_phase(175, 49, 0);
		run_phase(175, 0, 49);
		run_phase(175, 24, 24);
		repeat (300) @(posedge clk);

		$display("Checked %0d of %0d transactions: all opcodes, edge operands, random",
			checked_count, sent_count);
		$display("operands over four backpressure phases.");
		if (fail_count == 0 && expected_fracs.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#40ms;
		$display("Verification failed");
		$finish;
	end
endmodule
